/* design/bisr_pkg.sv */
// ----------------------------------------------------------------------------
// bisr_pkg
// shared types and constants of the bounded id set registry
// ----------------------------------------------------------------------------
package bisr_pkg;

  localparam logic [31:0] ID_INVALID = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_MATCH      = 2'd2,
    OP_LIST       = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_PERM  = 3'd1,
    ST_INVAL = 3'd2,
    ST_EXIST = 3'd3,
    ST_FULL  = 3'd4,
    ST_NOENT = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_SH_RD,
    S_SH_WR,
    S_LIST_RD,
    S_LIST_OUT
  } state_e;

endpackage

/* design/bounded_id_set_registry_unit.sv */
// ----------------------------------------------------------------------------
// bounded_id_set_registry_unit
// ordered set of up to DEPTH user ids held in one synchronous memory
// ----------------------------------------------------------------------------
// a request is taken at a rising edge with start high and busy low. op selects
// register, unregister, match or list. each result shows for one cycle with
// valid_o high; the receiver cannot stall, so results are never held.
// the ids sit in a single-port-read, single-port-write memory with registered
// read data; every lookup walks the stored entries one read at a time.
// a rejected register or unregister and a list of an empty set are answered
// straight from idle. match and register read and compare one entry at a
// time until a hit or the end of the set; unregister scans the same way, then
// moves each later entry down one position with a read and a write. list
// reads each entry in turn and shows it as one result.
// the scan loop does one read and one compare per entry.
// busy stays high until the last result has been loaded into the output
// register; the next request can be taken in the cycle that result shows.
// reset empties the set; memory contents are not cleared, since no position
// at or above the count is ever read.
// ----------------------------------------------------------------------------
module bounded_id_set_registry_unit
  import bisr_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [31:0] id_value_i,
  input  logic        caller_privileged_i,
  output logic        valid_o,
  output logic [2:0]  status_o,
  output logic        found_o,
  output logic [5:0]  entry_index_o,
  output logic [31:0] entry_id_o,
  output logic        entry_valid_o,
  output logic [6:0]  entry_count_o,
  output logic        last_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] ptr_nx;
  op_e           op_q, op_d;
  logic [31:0]   id_q, id_d;

  logic [31:0]   mem_q [DEPTH];
  logic [31:0]   rdata_q;
  logic          mem_we, mem_re;
  logic [IW-1:0] waddr, raddr;
  logic [31:0]   wdata;

  logic          res_vld_q, res_vld_d;
  status_e       res_status_q, res_status_d;
  logic          res_found_q, res_found_d;
  logic [5:0]    res_index_q, res_index_d;
  logic [31:0]   res_id_q, res_id_d;
  logic          res_evalid_q, res_evalid_d;
  logic [6:0]    res_count_q, res_count_d;
  logic          res_last_q, res_last_d;

  logic accept, early_rej, list_empty, hit, at_end, shift_end, list_end, full;

  assign accept     = start && !busy;
  assign early_rej  = (op_i == OP_REGISTER || op_i == OP_UNREGISTER) &&
                      (!caller_privileged_i || id_value_i == ID_INVALID);
  assign list_empty = (op_i == OP_LIST) && (count_q == '0);
  assign ptr_nx     = ptr_q + CW'(1);
  assign hit        = (rdata_q == id_q);
  assign at_end     = (ptr_q == count_q);
  assign shift_end  = (ptr_nx == count_q);
  assign list_end   = (ptr_nx == count_q);
  assign full       = (count_q == FULL_COUNT);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (early_rej || list_empty) begin
            state_d = S_IDLE;
          end else if (op_i == OP_LIST) begin
            state_d = S_LIST_RD;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = at_end ? S_IDLE : S_CMP;
      end
      S_CMP: begin
        if (hit) begin
          state_d = (op_q == OP_UNREGISTER) ? S_SH_RD : S_IDLE;
        end else begin
          state_d = S_RD;
        end
      end
      S_SH_RD: begin
        state_d = shift_end ? S_IDLE : S_SH_WR;
      end
      S_SH_WR: begin
        state_d = S_SH_RD;
      end
      S_LIST_RD: begin
        state_d = S_LIST_OUT;
      end
      S_LIST_OUT: begin
        state_d = list_end ? S_IDLE : S_LIST_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // datapath and results
  always_comb begin
    count_d      = count_q;
    ptr_d        = ptr_q;
    op_d         = op_q;
    id_d         = id_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    waddr        = ptr_q[IW-1:0];
    raddr        = ptr_q[IW-1:0];
    wdata        = rdata_q;
    res_vld_d    = 1'b0;
    res_status_d = ST_OK;
    res_found_d  = 1'b0;
    res_index_d  = '0;
    res_id_d     = '0;
    res_evalid_d = 1'b0;
    res_last_d   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d  = op_e'(op_i);
          id_d  = id_value_i;
          ptr_d = '0;
          if (early_rej) begin
            res_vld_d    = 1'b1;
            res_status_d = !caller_privileged_i ? ST_PERM : ST_INVAL;
          end else if (list_empty) begin
            res_vld_d = 1'b1;
          end
        end
      end
      S_RD: begin
        if (at_end) begin
          res_vld_d = 1'b1;
          case (op_q)
            OP_REGISTER: begin
              if (full) begin
                res_status_d = ST_FULL;
              end else begin
                mem_we  = 1'b1;
                waddr   = count_q[IW-1:0];
                wdata   = id_q;
                count_d = count_q + CW'(1);
              end
            end
            OP_UNREGISTER: res_status_d = ST_NOENT;
            default:       res_status_d = ST_OK;
          endcase
        end else begin
          mem_re = 1'b1;
        end
      end
      S_CMP: begin
        if (hit) begin
          case (op_q)
            OP_REGISTER: begin
              res_vld_d    = 1'b1;
              res_status_d = ST_EXIST;
            end
            OP_MATCH: begin
              res_vld_d   = 1'b1;
              res_found_d = 1'b1;
              res_index_d = 6'(ptr_q);
            end
            default: ;
          endcase
        end else begin
          ptr_d = ptr_nx;
        end
      end
      S_SH_RD: begin
        if (shift_end) begin
          count_d   = count_q - CW'(1);
          res_vld_d = 1'b1;
        end else begin
          mem_re = 1'b1;
          raddr  = ptr_nx[IW-1:0];
        end
      end
      S_SH_WR: begin
        mem_we = 1'b1;
        ptr_d  = ptr_nx;
      end
      S_LIST_RD: begin
        mem_re = 1'b1;
      end
      S_LIST_OUT: begin
        res_vld_d    = 1'b1;
        res_index_d  = 6'(ptr_q);
        res_id_d     = rdata_q;
        res_evalid_d = 1'b1;
        res_last_d   = list_end;
        ptr_d        = ptr_nx;
      end
      default: ;
    endcase
    res_count_d = 7'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    op_q         <= op_d;
    id_q         <= id_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_index_q  <= res_index_d;
    res_id_q     <= res_id_d;
    res_evalid_q <= res_evalid_d;
    res_count_q  <= res_count_d;
    res_last_q   <= res_last_d;
  end

  // id storage
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign valid_o       = res_vld_q;
  assign status_o      = res_status_q;
  assign found_o       = res_found_q;
  assign entry_index_o = res_index_q;
  assign entry_id_o    = res_id_q;
  assign entry_valid_o = res_evalid_q;
  assign entry_count_o = res_count_q;
  assign last_o        = res_last_q;

endmodule
